>>> sv/ieb_pkg.sv
package ieb_pkg;

    localparam int FRAME_WORDS = 39;
    localparam int WORD_W      = 16;
    localparam int INDEX_W     = 6;

    localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(FRAME_WORDS - 1);

    // Ones'-complement sum of every constant word covered by the checksum:
    // pseudo-header length and next header, ICMPv6 type/code, identifier,
    // sequence and the 0x41 payload, already folded to 16 bits.
    localparam logic [WORD_W-1:0] CSUM_INIT = 16'h8F2F;

    localparam logic [1:0] REG_LOCAL_MAC     = 2'd0;
    localparam logic [1:0] REG_SRC_ADDR_HIGH = 2'd1;
    localparam logic [1:0] REG_SRC_ADDR_LOW  = 2'd2;

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_SUM   = 2'd1,
        KIND_CSUM  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [INDEX_W-1:0] index;
        kind_t              kind;
    } cell_t;

    function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

endpackage

>>> sv/ieb_cell.sv
module ieb_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  logic           shift,
    input  ieb_pkg::cell_t load_data,
    input  ieb_pkg::cell_t shift_data,
    input  logic           shift_valid,
    output ieb_pkg::cell_t q,
    output logic           q_valid
);
    import ieb_pkg::*;

    cell_t data_reg, data_next;
    logic  valid_reg, valid_next;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (load) begin
            data_next  = load_data;
            valid_next = 1'b1;
        end else if (shift) begin
            data_next  = shift_data;
            valid_next = shift_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign q       = data_reg;
    assign q_valid = valid_reg;

endmodule

>>> sv/ieb_csum.sv
module ieb_csum (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ieb_pkg::cell_t             head,
    input  logic                       pop,
    output logic [ieb_pkg::WORD_W-1:0] frame_word
);
    import ieb_pkg::*;

    logic [WORD_W-1:0] acc_reg, acc_next;

    always_comb begin
        acc_next = acc_reg;
        if (pop) begin
            case (head.kind)
                KIND_SUM:  acc_next = oc_add(acc_reg, head.word);
                // checksum word gone: rearm for the next frame
                KIND_CSUM: acc_next = CSUM_INIT;
                default:   acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= CSUM_INIT;
        end else begin
            acc_reg <= acc_next;
        end
    end

    // all summed words leave the head before the checksum slot reaches it
    assign frame_word = (head.kind == KIND_CSUM) ? ~acc_reg : head.word;

endmodule

>>> sv/icmpv6_echo_frame_builder_unit.sv
// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid / s_tready  s_tdata: target_addr_high, target_addr_low
// m_       out        m_tvalid / m_tready  m_tdata: frame_word, word_index; m_tlast
// cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One address in gives 39 words out, one word per cycle while m_tready is high,
// so a new address is taken once per frame; the 39-cell shift chain sets that.
// A one-entry input register takes the next address while the chain still drains.
// The chain reloads in the same cycle its last word leaves: no bubble between frames.
// Reset (aresetn low, synchronous) empties the chain and input register and
// clears the configuration. A stall on m_ freezes the chain.
module icmpv6_echo_frame_builder_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] target_addr_high, [127:64] target_addr_low
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // [15:0] frame_word, [21:16] word_index, [23:22] zero
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    import ieb_pkg::*;

    logic [47:0]  local_mac_reg;
    logic [63:0]  src_high_reg;
    logic [63:0]  src_low_reg;
    logic [127:0] in_data_reg;
    logic         in_full_reg, in_full_next;

    cell_t img [FRAME_WORDS];
    cell_t cell_q [FRAME_WORDS+1];
    logic  cell_v [FRAME_WORDS+1];

    logic  pop, chain_load;
    logic [63:0] th, tl;
    logic [WORD_W-1:0] head_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_mac_reg <= '0;
            src_high_reg  <= '0;
            src_low_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_LOCAL_MAC:     local_mac_reg <= cfg_data[47:0];
                REG_SRC_ADDR_HIGH: src_high_reg  <= cfg_data;
                REG_SRC_ADDR_LOW:  src_low_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign pop        = m_tvalid && m_tready;
    assign chain_load = in_full_reg && (!cell_v[0] || (pop && cell_q[0].index == LAST_INDEX));
    assign s_tready   = !in_full_reg;

    always_comb begin
        in_full_next = in_full_reg;
        if (s_tvalid && s_tready) begin
            in_full_next = 1'b1;
        end else if (chain_load) begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg <= 1'b0;
        end else begin
            in_full_reg <= in_full_next;
        end
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    assign th = in_data_reg[63:0];
    assign tl = in_data_reg[127:64];

    // frame image loaded into all cells of the chain at once
    always_comb begin
        for (int k = 0; k < FRAME_WORDS; k++) begin
            img[k].word  = '0;
            img[k].index = INDEX_W'(k);
            img[k].kind  = KIND_PLAIN;
        end
        img[0].word  = 16'h3333;
        img[1].word  = tl[31:16];
        img[2].word  = tl[15:0];
        img[3].word  = local_mac_reg[47:32];
        img[4].word  = local_mac_reg[31:16];
        img[5].word  = local_mac_reg[15:0];
        img[6].word  = 16'h86DD;
        img[7].word  = 16'h6000;
        img[8].word  = 16'h0000;
        img[9].word  = 16'h0018;
        img[10].word = 16'h3A40;
        for (int j = 0; j < 4; j++) begin
            img[11+j].word = src_high_reg[63-16*j -: 16];
            img[15+j].word = src_low_reg[63-16*j -: 16];
            img[19+j].word = th[63-16*j -: 16];
            img[23+j].word = tl[63-16*j -: 16];
        end
        for (int j = 11; j < 27; j++) begin
            img[j].kind = KIND_SUM;
        end
        img[27].word = 16'h8000;
        img[28].kind = KIND_CSUM;
        img[29].word = 16'h04D2;
        img[30].word = 16'h0001;
        for (int j = 31; j < FRAME_WORDS; j++) begin
            img[j].word = 16'h4141;
        end
    end

    assign cell_q[FRAME_WORDS] = '0;
    assign cell_v[FRAME_WORDS] = 1'b0;

    for (genvar g = 0; g < FRAME_WORDS; g++) begin : g_chain
        ieb_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .load        (chain_load),
            .shift       (pop),
            .load_data   (img[g]),
            .shift_data  (cell_q[g+1]),
            .shift_valid (cell_v[g+1]),
            .q           (cell_q[g]),
            .q_valid     (cell_v[g])
        );
    end

    ieb_csum u_csum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (cell_q[0]),
        .pop        (pop),
        .frame_word (head_word)
    );

    assign m_tvalid = cell_v[0];
    assign m_tdata  = {2'b00, cell_q[0].index, head_word};
    assign m_tlast  = (cell_q[0].index == LAST_INDEX);

endmodule

>>> sv/ieb_checker.sv
module ieb_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [23:0]  m_tdata,
    input logic         m_tlast
);
    import ieb_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[21:16] == LAST_INDEX)))
        else $error("tlast does not match word index");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[21:16] == INDEX_W'($past(m_tdata[21:16]) + 6'd1)))
        else $error("frame word missing or out of order");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || (m_tdata[21:16] == '0))
        else $error("new frame does not start at word zero");

endmodule

bind icmpv6_echo_frame_builder_unit ieb_checker u_ieb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> bench/icmpv6_frame_checker.sv
module icmpv6_frame_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] target_addr_high, [127:64] target_addr_low
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [23:0]  m_tdata,   // [15:0] frame_word, [21:16] word_index, [23:22] zero
    input  logic         m_tlast,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    output int           error_count,
    output int           words_pending
);

    localparam int FRAME_BYTES = 78;
    localparam int ICMP_OFF    = 54;
    localparam int SUM_FIRST   = 22;  // checksum covers source address up to frame end

    localparam logic [7:0]  MCAST_PREFIX    = 8'h33;
    localparam logic [15:0] ETHERTYPE_IPV6  = 16'h86DD;
    localparam logic [7:0]  IP_VERSION_BYTE = 8'h60;
    localparam logic [15:0] ICMP_LEN        = 16'd24;
    localparam logic [7:0]  NEXT_HDR_ICMPV6 = 8'd58;
    localparam logic [7:0]  HOP_LIMIT       = 8'd64;
    localparam logic [7:0]  ECHO_REQUEST    = 8'd128;
    localparam logic [15:0] ECHO_ID         = 16'd1234;
    localparam logic [15:0] ECHO_SEQ        = 16'd1;
    localparam logic [7:0]  PAYLOAD_BYTE    = 8'h41;

    typedef struct packed {
        logic [ieb_pkg::WORD_W-1:0]  word;
        logic [ieb_pkg::INDEX_W-1:0] index;
        logic                        last;
    } echo_word_t;

    echo_word_t  expected_words [$];
    logic [47:0] local_mac_q;
    logic [63:0] src_high_q;
    logic [63:0] src_low_q;
    int          mismatches = 0;

    task automatic predict_echo_frame(input logic [63:0] th, input logic [63:0] tl);
        logic [7:0]  fb [0:FRAME_BYTES-1];
        logic [31:0] sum;
        logic [15:0] csum;
        echo_word_t  w;
        int          i;
        for (i = 0; i < FRAME_BYTES; i++) fb[i] = 8'h00;
        fb[0] = MCAST_PREFIX;
        fb[1] = MCAST_PREFIX;
        for (i = 0; i < 4; i++) fb[2 + i] = tl[31 - 8 * i -: 8];
        for (i = 0; i < 6; i++) fb[6 + i] = local_mac_q[47 - 8 * i -: 8];
        fb[12] = ETHERTYPE_IPV6[15:8];
        fb[13] = ETHERTYPE_IPV6[7:0];
        fb[14] = IP_VERSION_BYTE;
        fb[18] = ICMP_LEN[15:8];
        fb[19] = ICMP_LEN[7:0];
        fb[20] = NEXT_HDR_ICMPV6;
        fb[21] = HOP_LIMIT;
        for (i = 0; i < 8; i++) begin
            fb[22 + i] = src_high_q[63 - 8 * i -: 8];
            fb[30 + i] = src_low_q[63 - 8 * i -: 8];
            fb[38 + i] = th[63 - 8 * i -: 8];
            fb[46 + i] = tl[63 - 8 * i -: 8];
        end
        fb[ICMP_OFF]     = ECHO_REQUEST;
        fb[ICMP_OFF + 4] = ECHO_ID[15:8];
        fb[ICMP_OFF + 5] = ECHO_ID[7:0];
        fb[ICMP_OFF + 6] = ECHO_SEQ[15:8];
        fb[ICMP_OFF + 7] = ECHO_SEQ[7:0];
        for (i = ICMP_OFF + 8; i < FRAME_BYTES; i++) fb[i] = PAYLOAD_BYTE;

        // pseudo-header length and next header, then addresses and body
        // with the checksum field still zero
        sum = 32'(ICMP_LEN) + 32'(NEXT_HDR_ICMPV6);
        for (i = SUM_FIRST; i < FRAME_BYTES; i += 2) sum += {16'h0000, fb[i], fb[i + 1]};
        while (sum[31:16] != 16'h0000) sum = {16'h0000, sum[15:0]} + {16'h0000, sum[31:16]};
        // an all-ones sum goes out as zero, no substitution
        csum = ~sum[15:0];
        fb[ICMP_OFF + 2] = csum[15:8];
        fb[ICMP_OFF + 3] = csum[7:0];

        for (i = 0; i < ieb_pkg::FRAME_WORDS; i++) begin
            w.word  = {fb[2 * i], fb[2 * i + 1]};
            w.index = ieb_pkg::INDEX_W'(i);
            w.last  = (i == ieb_pkg::FRAME_WORDS - 1);
            expected_words.push_back(w);
        end
    endtask

    always @(posedge aclk) begin : monitor
        echo_word_t got;
        echo_word_t want;
        if (!aresetn) begin
            expected_words.delete();
            local_mac_q = '0;
            src_high_q  = '0;
            src_low_q   = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.word  = m_tdata[15:0];
                got.index = m_tdata[21:16];
                got.last  = m_tlast;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word: expected none, %s %h index %0d last %0b",
                             $time, "got word", got.word, got.index, got.last);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        $display("%0t: word mismatch: expected word %h index %0d last %0b,",
                                 $time, want.word, want.index, want.last);
                        $display("%0t:                got word %h index %0d last %0b",
                                 $time, got.word, got.index, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_echo_frame(s_tdata[63:0], s_tdata[127:64]);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ieb_pkg::REG_LOCAL_MAC:     local_mac_q = cfg_data[47:0];
                    ieb_pkg::REG_SRC_ADDR_HIGH: src_high_q  = cfg_data;
                    ieb_pkg::REG_SRC_ADDR_LOW:  src_low_q   = cfg_data;
                    default: ;  // drop writes past the register list
                endcase
            end
        end
        error_count   <= mismatches;
        words_pending <= expected_words.size();
    end

endmodule

>>> bench/tb_icmpv6_echo_frame_builder_unit.sv
module tb_icmpv6_echo_frame_builder_unit;

    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         RX_HOLD_CYCLES = 400;
    localparam int         DRAIN_CYCLES   = 2 * ieb_pkg::FRAME_WORDS + 8;
    localparam int         RAND_PHASES    = 4;
    localparam int         PHASE_ITEMS    = 42;
    localparam logic [1:0] REG_UNUSED     = 2'd3;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_MOSTLY,
        RX_PERIODIC
    } rx_mode_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [23:0]  m_tdata;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [63:0]  cfg_data  = '0;

    int error_count;
    int words_pending;
    int cycle_count = 0;
    int burst_left  = 0;
    int nogap_left  = 0;
    bit rx_hold_req = 1'b0;

    icmpv6_echo_frame_builder_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    icmpv6_frame_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .words_pending (words_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_icmpv6_echo_frame_builder_unit NOT OK");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_reg_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return rand64();
    endfunction

    // returns the address in s_tdata layout: {low, high}
    function automatic logic [127:0] random_target();
        logic [63:0] th;
        logic [63:0] tl;
        int          roll;
        th   = rand64();
        tl   = rand64();
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            th = '0;
            tl = '0;
        end else if (roll < 14) begin
            th = '1;
            tl = '1;
        end else if (roll < 40) begin
            // solicited-node multicast
            th = 64'hFF02_0000_0000_0000;
            tl = {32'h0000_0001, 8'hFF, tl[23:0]};
        end else if (roll < 55) begin
            th = 64'hFE80_0000_0000_0000;
        end
        return {tl, th};
    endfunction

    function automatic int next_gap();
        int roll;
        if (nogap_left > 0) begin
            nogap_left--;
            return 0;
        end
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll       = $urandom_range(0, 9);
        burst_left = (roll == 0) ? $urandom_range(12, 24) : $urandom_range(0, 6);
        if (roll < 2) return $urandom_range(20, 60);
        return $urandom_range(1, 8);
    endfunction

    // leaves s_tvalid high when the next word follows without a gap
    task automatic offer_addr(input logic [63:0] th, input logic [63:0] tl);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {tl, th};
        do @(posedge aclk); while (!s_tready);
        gap = next_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic write_config(input logic [63:0] mac, input logic [63:0] hi,
                                input logic [63:0] lo, input bit poke_unused);
        write_reg(ieb_pkg::REG_LOCAL_MAC, mac);
        write_reg(ieb_pkg::REG_SRC_ADDR_HIGH, hi);
        write_reg(ieb_pkg::REG_SRC_ADDR_LOW, lo);
        if (poke_unused) write_reg(REG_UNUSED, rand64());
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : rx_side
        rx_mode_t mode;
        int       mode_left;
        int       phase;
        mode      = RX_ALWAYS;
        mode_left = 0;
        phase     = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                // hold off long enough for the block to back up into s_tready
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            if (mode_left == 0) begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            phase++;
            case (mode)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_COIN:   m_tready <= ($urandom_range(0, 1) != 0);
                RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
                default:   m_tready <= ((phase % 7) >= 3);
            endcase
        end
    end

    initial begin : stimulus
        logic [127:0] d;
        int           p;
        int           n;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // registers at reset values
        offer_addr('0, '0);
        offer_addr('1, '1);
        // variable words sum to 0x70D0: checksum sum is all ones, sent as zero
        offer_addr('0, 64'h0000_0000_0000_70D0);
        offer_addr(64'hFF02_0000_0000_0000, 64'h0000_0001_FF12_3456);
        offer_addr(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        offer_addr(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        s_tvalid <= 1'b0;
        wait_drained();

        write_config('1, '1, '1, 1'b1);
        offer_addr('0, '0);
        offer_addr('1, '1);
        offer_addr('0, 64'h0000_0000_FFFF_FFFF);
        offer_addr(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000);
        s_tvalid <= 1'b0;
        wait_drained();

        // upper bits of the MAC write are dropped
        write_config(64'hDEAD_0123_4567_89AB, 64'hFE80_0000_0000_0000,
                     64'h0211_22FF_FE33_4455, 1'b1);
        offer_addr(64'hFE80_0000_0000_0000, 64'h0000_0000_0000_0001);
        offer_addr(64'hFF02_0000_0000_0000, 64'h0000_0000_0000_0001);
        offer_addr('0, '1);
        offer_addr('1, '0);
        s_tvalid <= 1'b0;
        wait_drained();

        for (p = 0; p < RAND_PHASES; p++) begin
            if (p == RAND_PHASES - 1)
                write_config('0, '0, '0, 1'b0);
            else
                write_config(rand_reg_value(), rand_reg_value(), rand_reg_value(), p == 0);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 3) begin
                    rx_hold_req = 1'b1;
                    nogap_left  = 8;
                end
                d = random_target();
                offer_addr(d[63:0], d[127:64]);
            end
            s_tvalid <= 1'b0;
            wait_drained();
        end

        if (error_count == 0 && words_pending == 0)
            $display("tb_icmpv6_echo_frame_builder_unit OK");
        else
            $display("tb_icmpv6_echo_frame_builder_unit NOT OK");
        $finish;
    end

endmodule

>>> files.f
sv/ieb_pkg.sv
sv/ieb_cell.sv
sv/ieb_csum.sv
sv/icmpv6_echo_frame_builder_unit.sv
sv/ieb_checker.sv
bench/icmpv6_frame_checker.sv
bench/tb_icmpv6_echo_frame_builder_unit.sv
